@@ hdl/cmq_pkg.sv @@
// Shared constants, types and helpers for the circular message queue.
package cmq_pkg;

    localparam int MAX_DEPTH  = 64;
    localparam int ENTRY_BITS = 64;
    localparam int IDX_W      = $clog2(MAX_DEPTH);
    localparam int CNT_W      = $clog2(MAX_DEPTH + 1);
    localparam int DATA_W     = 64;
    localparam int TAG_W      = 8;
    localparam int CFG_W      = 8;

    localparam logic [1:0] KIND_SEND   = 2'd0;
    localparam logic [1:0] KIND_OLDEST = 2'd1;
    localparam logic [1:0] KIND_NEWEST = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADTAG = 2'd3;

    localparam logic CFG_QUEUE_DEPTH = 1'b0;
    localparam logic CFG_CHANNEL_ID  = 1'b1;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_DEPTH - 1);

    typedef struct packed {
        logic                  we;
        logic [IDX_W-1:0]      waddr;
        logic [ENTRY_BITS-1:0] wdata;
        logic [IDX_W-1:0]      raddr;
    } t_mem_req;

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] depth);
        logic [IDX_W:0] n;
        n = {1'b0, idx} + (IDX_W+1)'(1);
        if (32'(n) >= 32'(depth)) begin
            return '0;
        end
        return n[IDX_W-1:0];
    endfunction

endpackage

@@ hdl/cmq_mem.sv @@
// Entry storage: one write port and one registered read port.
module cmq_mem
    import cmq_pkg::*;
(
    input  logic                  i_clk,
    input  t_mem_req              i_req,
    output logic [ENTRY_BITS-1:0] o_rdata
);

    logic [ENTRY_BITS-1:0] r_mem [MAX_DEPTH];
    logic [ENTRY_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/cmq_ctrl.sv @@
// Queue control: tag check, index and count update, result registers.
module cmq_ctrl
    import cmq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_kind,
    input  logic [TAG_W-1:0]  i_id_tag,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic [CNT_W-1:0]  i_depth,
    input  logic [TAG_W-1:0]  i_channel_id,
    output t_mem_req          o_mem_req,
    output logic              o_done,
    output logic [1:0]        o_status,
    output logic              o_rd_ok,
    output logic [CNT_W-1:0]  o_occupancy
);

    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_done;
    logic [1:0]       r_status, n_status;
    logic             r_rd_ok, n_rd_ok;
    logic [CNT_W-1:0] r_occ;

    always_comb begin
        n_head          = r_head;
        n_tail          = r_tail;
        n_count         = r_count;
        n_status        = ST_OK;
        n_rd_ok         = 1'b0;
        o_mem_req.we    = 1'b0;
        o_mem_req.waddr = advance(r_tail, i_depth);
        o_mem_req.wdata = i_write_data[ENTRY_BITS-1:0];
        o_mem_req.raddr = r_head;
        if (i_id_tag != i_channel_id) begin
            n_status = ST_BADTAG;
        end else if (i_kind == KIND_SEND) begin
            if (r_count >= i_depth) begin
                n_status = ST_FULL;
            end else begin
                n_tail       = advance(r_tail, i_depth);
                o_mem_req.we = i_accept;
                n_count      = r_count + CNT_W'(1);
            end
        end else if (r_count == '0) begin
            n_status = ST_EMPTY;
        end else if (i_kind == KIND_NEWEST) begin
            o_mem_req.raddr = r_tail;
            n_rd_ok         = 1'b1;
            n_head          = '0;
            n_tail          = IDX_LAST;
            n_count         = '0;
        end else begin
            o_mem_req.raddr = r_head;
            n_rd_ok         = 1'b1;
            n_head          = advance(r_head, i_depth);
            n_count         = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= IDX_LAST;
            r_count <= '0;
            r_done  <= 1'b0;
            r_rd_ok <= 1'b0;
        end else begin
            r_done <= i_accept;
            if (i_accept) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
                r_rd_ok <= n_rd_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_status <= n_status;
            r_occ    <= n_count;
        end
    end

    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_rd_ok     = r_rd_ok;
    assign o_occupancy = r_occ;

endmodule

@@ hdl/circular_message_queue.sv @@
// Circular message queue top level: configuration registers and result port.
// Each request (send, receive oldest and receive newest) gives exactly
// one result, shown on the result ports for one cycle with o_done high, in
// the cycle after the request is taken; the read data comes from the registered
// read port of the entry memory. A request is taken in every cycle, so busy
// stays low. Results cannot be held off and must be captured when o_done is
// high. Write configuration only while no result is pending.
module circular_message_queue
    import cmq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_kind,
    input  logic [TAG_W-1:0]  i_id_tag,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output logic              o_done,
    output logic [1:0]        o_status,
    output logic [DATA_W-1:0] o_read_data,
    output logic [6:0]        o_occupancy
);

    logic [CNT_W-1:0]      r_depth;
    logic [TAG_W-1:0]      r_channel_id;
    logic [CNT_W-1:0]      depth_wr;
    logic                  accept;
    t_mem_req              mem_req;
    logic [ENTRY_BITS-1:0] mem_rdata;
    logic                  rd_ok;
    logic [CNT_W-1:0]      occ;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb begin
        if (i_cfg_data == '0) begin
            depth_wr = CNT_W'(1);
        end else if (32'(i_cfg_data) > 32'(MAX_DEPTH)) begin
            depth_wr = CNT_W'(MAX_DEPTH);
        end else begin
            depth_wr = CNT_W'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth      <= CNT_W'(MAX_DEPTH);
            r_channel_id <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_QUEUE_DEPTH: r_depth      <= depth_wr;
                CFG_CHANNEL_ID:  r_channel_id <= i_cfg_data[TAG_W-1:0];
                default:         r_depth      <= r_depth;
            endcase
        end
    end

    cmq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_kind       (i_kind),
        .i_id_tag     (i_id_tag),
        .i_write_data (i_write_data),
        .i_depth      (r_depth),
        .i_channel_id (r_channel_id),
        .o_mem_req    (mem_req),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_rd_ok      (rd_ok),
        .o_occupancy  (occ)
    );

    cmq_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign o_read_data = rd_ok ? DATA_W'(mem_rdata) : '0;
    assign o_occupancy = 7'(occ);

endmodule
